@@ hdl/bdq_pkg.sv @@
// Shared types and constants for the bounded deque.
package bdq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int WORD_W       = 32;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_PEEK       = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_RESP = 3'b100
  } state_t;

endpackage

@@ hdl/bdq_mem.sv @@
// Word store: one write port, two registered read ports.
module bdq_mem #(
  parameter int DEPTH  = bdq_pkg::CAPACITY_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [ADDR_W-1:0]                 waddr,
  input  logic signed [bdq_pkg::WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0]                 raddr_a,
  input  logic [ADDR_W-1:0]                 raddr_b,
  output logic signed [bdq_pkg::WORD_W-1:0] rdata_a,
  output logic signed [bdq_pkg::WORD_W-1:0] rdata_b
);

  logic signed [bdq_pkg::WORD_W-1:0] mem_r [DEPTH];
  logic signed [bdq_pkg::WORD_W-1:0] rdata_a_r;
  logic signed [bdq_pkg::WORD_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

@@ hdl/bdq_ctrl.sv @@
// Pointer, count and sequencing logic for the bounded deque.
module bdq_ctrl #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF,
  parameter int ADDR_W   = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [bdq_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [bdq_pkg::WORD_W-1:0]   in_value,
  output logic                                out_valid,
  output logic [bdq_pkg::STATUS_W-1:0]        out_status,
  output logic [bdq_pkg::COUNT_W-1:0]         out_count,
  output logic signed [bdq_pkg::WORD_W-1:0]   out_front_value,
  output logic signed [bdq_pkg::WORD_W-1:0]   out_rear_value,
  output logic                                mem_we,
  output logic [ADDR_W-1:0]                   mem_waddr,
  output logic signed [bdq_pkg::WORD_W-1:0]   mem_wdata,
  output logic [ADDR_W-1:0]                   mem_raddr_a,
  output logic [ADDR_W-1:0]                   mem_raddr_b,
  input  logic signed [bdq_pkg::WORD_W-1:0]   mem_rdata_a,
  input  logic signed [bdq_pkg::WORD_W-1:0]   mem_rdata_b
);

  localparam logic [CNT_W:0]  CAP_EXT = (CNT_W+1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(CAPACITY - 1);

  function automatic logic [ADDR_W-1:0] slot_at(input logic [ADDR_W-1:0] head,
                                                input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
    if (sum >= CAP_EXT) begin
      sum = sum - CAP_EXT;
    end
    return ADDR_W'(sum);
  endfunction

  bdq_pkg::state_t                 state_r, state_nxt;
  logic [ADDR_W-1:0]               head_r, head_nxt;
  logic [CNT_W-1:0]                occ_r, occ_nxt;
  logic [bdq_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic                            accept;
  logic                            full;
  logic                            empty;
  logic [CNT_W-1:0]                rear_off;

  assign accept = start && (state_r == bdq_pkg::ST_IDLE);
  assign full   = (occ_r == CAP_CNT);
  assign empty  = (occ_r == '0);

  always_comb begin
    head_nxt   = head_r;
    occ_nxt    = occ_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = head_r;
    mem_wdata  = in_value;
    if (accept) begin
      status_nxt = bdq_pkg::STAT_DONE;
      unique case (bdq_pkg::kind_t'(in_kind))
        bdq_pkg::KIND_PUSH_FRONT: begin
          if (full) begin
            status_nxt = bdq_pkg::STAT_OVERFLOW;
          end else begin
            head_nxt  = (head_r == '0) ? LAST_SLOT : head_r - ADDR_W'(1);
            mem_we    = 1'b1;
            mem_waddr = head_nxt;
            occ_nxt   = occ_r + CNT_W'(1);
          end
        end
        bdq_pkg::KIND_PUSH_REAR: begin
          if (full) begin
            status_nxt = bdq_pkg::STAT_OVERFLOW;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = slot_at(head_r, occ_r);
            occ_nxt   = occ_r + CNT_W'(1);
          end
        end
        bdq_pkg::KIND_POP_FRONT: begin
          if (empty) begin
            status_nxt = bdq_pkg::STAT_UNDERFLOW;
          end else begin
            head_nxt = (head_r == LAST_SLOT) ? '0 : head_r + ADDR_W'(1);
            occ_nxt  = occ_r - CNT_W'(1);
          end
        end
        bdq_pkg::KIND_POP_REAR: begin
          if (empty) begin
            status_nxt = bdq_pkg::STAT_UNDERFLOW;
          end else begin
            occ_nxt = occ_r - CNT_W'(1);
          end
        end
        default: begin
          status_nxt = bdq_pkg::STAT_DONE;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdq_pkg::ST_IDLE: if (start) state_nxt = bdq_pkg::ST_READ;
      bdq_pkg::ST_READ: state_nxt = bdq_pkg::ST_RESP;
      bdq_pkg::ST_RESP: state_nxt = bdq_pkg::ST_IDLE;
      default:          state_nxt = bdq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::ST_IDLE;
      head_r  <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  assign rear_off    = empty ? '0 : occ_r - CNT_W'(1);
  assign mem_raddr_a = head_r;
  assign mem_raddr_b = slot_at(head_r, rear_off);

  assign busy            = (state_r != bdq_pkg::ST_IDLE);
  assign out_valid       = (state_r == bdq_pkg::ST_RESP);
  assign out_status      = status_r;
  assign out_count       = bdq_pkg::COUNT_W'(occ_r);
  assign out_front_value = empty ? bdq_pkg::EMPTY_WORD : mem_rdata_a;
  assign out_rear_value  = empty ? bdq_pkg::EMPTY_WORD : mem_rdata_b;

endmodule

@@ hdl/bounded_deque.sv @@
// Top level of the bounded deque.
// A double-ended queue of CAPACITY signed 32-bit words in a circular buffer.
// Each command passes the idle, read and response states: the accept cycle
// updates pointers and writes a pushed word, the next cycle reads the front
// and rear words into the store's read registers, and the response state
// shows the result for one cycle with out_valid high. busy stays high from
// the cycle after start is taken until the result cycle ends; the receiver
// cannot stall and must take each result in the cycle it appears. A full or
// empty queue refuses a push or pop with overflow or underflow status; front
// and rear read as all ones when the queue is empty.
module bounded_deque #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bdq_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [bdq_pkg::WORD_W-1:0] in_value,
  output logic                              out_valid,
  output logic [bdq_pkg::STATUS_W-1:0]      out_status,
  output logic [bdq_pkg::COUNT_W-1:0]       out_count,
  output logic signed [bdq_pkg::WORD_W-1:0] out_front_value,
  output logic signed [bdq_pkg::WORD_W-1:0] out_rear_value
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  logic                              mem_we;
  logic [ADDR_W-1:0]                 mem_waddr;
  logic signed [bdq_pkg::WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]                 mem_raddr_a;
  logic [ADDR_W-1:0]                 mem_raddr_b;
  logic signed [bdq_pkg::WORD_W-1:0] mem_rdata_a;
  logic signed [bdq_pkg::WORD_W-1:0] mem_rdata_b;

  bdq_ctrl #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_count       (out_count),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr_a     (mem_raddr_a),
    .mem_raddr_b     (mem_raddr_b),
    .mem_rdata_a     (mem_rdata_a),
    .mem_rdata_b     (mem_rdata_b)
  );

  bdq_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

endmodule

@@ hdl/bdq_checker.sv @@
// Port-level assertions for the bounded deque, bound to the top level.
module bdq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [bdq_pkg::COUNT_W-1:0]       out_count,
  input logic signed [bdq_pkg::WORD_W-1:0] out_front_value,
  input logic signed [bdq_pkg::WORD_W-1:0] out_rear_value
);

  a_result_two_after: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid)
    else $error("result word missing two cycles after accept");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("busy not raised after accept");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result word outside busy window");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("block not idle after result word");

  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count == '0 |->
      out_front_value == bdq_pkg::EMPTY_WORD && out_rear_value == bdq_pkg::EMPTY_WORD)
    else $error("empty queue shows a word");

endmodule

bind bounded_deque bdq_checker u_bdq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_count       (out_count),
  .out_front_value (out_front_value),
  .out_rear_value  (out_rear_value)
);

@@ dv/tb_bounded_deque.sv @@
// Self-checking testbench for the bounded deque: directed and random commands against a predictor.
module tb_bounded_deque;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int DEPTH       = CAPACITY_DEF;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic signed [WORD_W-1:0] front;
    logic signed [WORD_W-1:0] rear;
  } deque_resp_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [KIND_W-1:0]        in_kind = '0;
  logic signed [WORD_W-1:0] in_value = '0;
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic [COUNT_W-1:0]       out_count;
  logic signed [WORD_W-1:0] out_front_value;
  logic signed [WORD_W-1:0] out_rear_value;

  logic signed [WORD_W-1:0] model_words [DEPTH];
  int unsigned              model_head = 0;
  int unsigned              model_fill = 0;

  deque_resp_t pending_resps [$];
  deque_resp_t want;
  int          idle_pct = 0;
  int          err_count = 0;
  int          stall_cycles = 0;

  bounded_deque #(.CAPACITY(DEPTH)) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_count       (out_count),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic deque_resp_t predict_deque_step(input logic [KIND_W-1:0] kind,
                                                     input logic signed [WORD_W-1:0] value);
    deque_resp_t r;
    r.status = STAT_DONE;
    case (kind)
      KIND_PUSH_FRONT: begin
        if (model_fill >= DEPTH) begin
          r.status = STAT_OVERFLOW;
        end else begin
          model_head = (model_head == 0) ? DEPTH - 1 : model_head - 1;
          model_words[model_head] = value;
          model_fill++;
        end
      end
      KIND_PUSH_REAR: begin
        if (model_fill >= DEPTH) begin
          r.status = STAT_OVERFLOW;
        end else begin
          model_words[(model_head + model_fill) % DEPTH] = value;
          model_fill++;
        end
      end
      KIND_POP_FRONT: begin
        if (model_fill == 0) begin
          r.status = STAT_UNDERFLOW;
        end else begin
          model_head = (model_head + 1) % DEPTH;
          model_fill--;
        end
      end
      KIND_POP_REAR: begin
        if (model_fill == 0) r.status = STAT_UNDERFLOW;
        else model_fill--;
      end
      default: ;
    endcase
    r.count = model_fill[COUNT_W-1:0];
    r.front = EMPTY_WORD;
    r.rear  = EMPTY_WORD;
    if (model_fill != 0) begin
      r.front = model_words[model_head];
      r.rear  = model_words[(model_head + model_fill - 1) % DEPTH];
    end
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] rand_word();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(input string what);
    $display("%0t: %s", $realtime, what);
    err_count++;
  endtask

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic signed [WORD_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      start    <= 1'b0;
      in_kind  <= KIND_W'($urandom);
      in_value <= $urandom;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (busy);
    pending_resps.push_back(predict_deque_step(kind, value));
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (pending_resps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_push(input logic signed [WORD_W-1:0] value);
    send_word($urandom_range(1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT, value);
  endtask

  task automatic send_pop();
    send_word($urandom_range(1) ? KIND_POP_REAR : KIND_POP_FRONT, rand_word());
  endtask

  task automatic test_empty_queue();
    send_word(KIND_POP_FRONT, 32'sd5);
    send_word(KIND_POP_REAR, -32'sd5);
    send_word(KIND_PEEK, 32'sd0);
    send_word(3'd7, -32'sd1);
  endtask

  task automatic test_word_extremes();
    send_word(KIND_PUSH_FRONT, 32'sh8000_0000);
    send_word(KIND_PUSH_REAR, 32'sh7fff_ffff);
    send_word(KIND_PUSH_FRONT, -32'sd1);
    send_word(KIND_PUSH_REAR, 32'sd0);
    send_word(3'd5, 32'sh5555_5555);
    send_word(3'd6, 32'shaaaa_aaaa);
    send_word(KIND_PEEK, 32'sh1234_5678);
    send_word(KIND_POP_REAR, 32'sd0);
    send_word(KIND_POP_FRONT, 32'sd0);
    send_word(KIND_POP_FRONT, 32'sd0);
    send_word(KIND_POP_REAR, 32'sd0);
    send_word(KIND_POP_REAR, 32'sd0);
  endtask

  task automatic test_fill_and_drain(input int rounds);
    repeat (rounds) begin
      while (model_fill < DEPTH) begin
        if ($urandom_range(99) < 15) send_pop();
        else send_push(rand_word());
      end
      repeat ($urandom_range(1, 3)) send_push(rand_word());
      if ($urandom_range(1)) send_word(KIND_PEEK, rand_word());
      while (model_fill > 0) begin
        if ($urandom_range(99) < 15) send_push(rand_word());
        else send_pop();
      end
      repeat ($urandom_range(1, 2)) send_pop();
    end
  endtask

  task automatic test_random_ops(input int num_items);
    int left;
    int burst;
    int push_pct;
    int r;
    left = num_items;
    while (left > 0) begin
      case ($urandom_range(2))
        0: push_pct = 70;
        1: push_pct = 50;
        default: push_pct = 30;
      endcase
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        r = $urandom_range(99);
        if (r < 5) send_word(KIND_W'($urandom_range(5, 7)), rand_word());
        else if (r < 10) send_word(KIND_PEEK, rand_word());
        else if ($urandom_range(99) < push_pct) send_push(rand_word());
        else send_pop();
        burst--;
        left--;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_resps.size() == 0) begin
        report_error("result with no command outstanding");
      end else begin
        want = pending_resps.pop_front();
        if (out_status !== want.status)
          report_error($sformatf("status got %0d expected %0d", out_status, want.status));
        if (out_count !== want.count)
          report_error($sformatf("count got %0d expected %0d", out_count, want.count));
        if (out_front_value !== want.front)
          report_error($sformatf("front got %h expected %h", out_front_value, want.front));
        if (out_rear_value !== want.rear)
          report_error($sformatf("rear got %h expected %h", out_rear_value, want.rear));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 0;
    test_empty_queue();
    test_word_extremes();
    test_fill_and_drain(4);
    wait_drain();

    idle_pct = 47;
    test_random_ops(450);
    wait_drain();

    idle_pct = 25;
    test_random_ops(450);
    test_fill_and_drain(4);
    wait_drain();

    idle_pct = 0;
    test_random_ops(400);
    wait_drain();
    repeat (8) @(posedge clk);

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ bounded_deque.f @@
hdl/bdq_pkg.sv
hdl/bdq_mem.sv
hdl/bdq_ctrl.sv
hdl/bounded_deque.sv
hdl/bdq_checker.sv
dv/tb_bounded_deque.sv
